### sv/bfsa_pkg.sv
// Package: shared types, constants and command codes for the segment allocator.
`timescale 1ns / 1ps
package bfsa_pkg;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int ADDR_BITS_DEF    = 16;
   localparam int LIMIT_BITS       = 17;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'h10000;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_BAD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_NO_SPACE = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] req_size;
      logic [15:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic [1:0]  status;
   } rsp_type;
endpackage

### sv/bfsa_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### sv/best_fit_segment_allocator_unit.sv
// Top level: best-fit heap segment allocator with split and coalesce.
`timescale 1ns / 1ps
// Usage:
//   Pulse start with a request on req_payload while busy is low. The block
//   raises busy, works the command against its segment table, and shows one
//   response on rsp_payload for exactly one cycle, marked by rsp_valid; busy
//   stays high through that cycle and drops on the next one, so the next
//   request may be taken once busy has dropped. The receiver cannot
//   stall the response.
//   csr_wr_en/csr_wr_data write heap_limit; write only while the block is idle.
// Sequence: allocate does one table scan and a decision step; on a split
//   or an append it then runs a shift pass and writes the new entry (S_PUT),
//   and a reused segment is rewritten (S_FIX). Free scans until it finds the
//   block (else it answers not found), then runs a compaction pass which
//   merges free neighbors while copying down, and a flush step. Every command
//   ends with the response states S_RSP and S_DONE; clear and a rejected
//   request go straight to them. Every step goes through one table RAM that
//   reads one entry a cycle with a registered read.
// Reset (synchronous): seg_count and heap_top clear, heap_limit returns to 65536; the table RAM
//   keeps no reset, since only entries below seg_count are read.
module best_fit_segment_allocator_unit #(
   parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES = bfsa_pkg::HEADER_BYTES_DEF,
   parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bfsa_pkg::req_type         req_payload,
   output logic                      rsp_valid,
   output bfsa_pkg::rsp_type         rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [bfsa_pkg::LIMIT_BITS-1:0] csr_wr_data
);
   import bfsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   // segment entry: start(18) size(18) free(1); widths cover sums past 16 bits
   localparam int VW = 18;
   localparam int EW = 2 * VW + 1;
   localparam logic [VW-1:0] HDR = VW'(HEADER_BYTES);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_SCAN  = 10'b0000000010,  // issue reads of the table
      S_PICK  = 10'b0000000100,  // decide after the scan
      S_SHIFT = 10'b0000001000,  // move entries up by one, from the top
      S_PUT   = 10'b0000010000,  // write the inserted entry
      S_FIX   = 10'b0000100000,  // rewrite the chosen entry
      S_COMP  = 10'b0001000000,  // compaction pass for free
      S_CFLUSH = 10'b0010000000, // write last merged entry
      S_DONE  = 10'b0100000000,
      S_RSP   = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic [VW-1:0] start;
      logic [VW-1:0] size;
      logic          free;
   } ent_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] top_ff, top_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [CW-1:0] ptr_ff, ptr_in;     // read pointer
   logic [CW-1:0] wptr_ff, wptr_in;   // write pointer for compaction
   logic          rv_ff, rv_in;       // read data valid next cycle
   logic [CW-1:0] rix_ff, rix_in;     // index of data arriving
   logic          found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   ent_type       bent_ff, bent_in;
   ent_type       acc_ff, acc_in;     // entry being merged
   logic          accv_ff, accv_in;
   ent_type       ins_ff, ins_in;     // entry to insert
   logic [CW-1:0] insk_ff, insk_in;   // insert position
   // remember whether the allocate split, for the entry rewrite
   logic          split_ff, split_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   ent_type       wr_data, rd_data;
   logic [EW-1:0] rd_raw;

   bfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(EW'(wr_data)),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );
   assign rd_data = ent_type'(rd_raw);

   // effective limit: min(limit, 65536, 2^ADDR_BITS); the limit is capped at 65536 here
   logic [VW-1:0] eff_limit;
   always_comb begin
      eff_limit = (VW'(limit_ff) > VW'(17'h10000)) ? VW'(17'h10000) : VW'(limit_ff);
      if (ADDR_BITS < 17 && eff_limit > (VW'(1) << ADDR_BITS)) begin
         eff_limit = VW'(1) << ADDR_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   logic [VW-1:0] req_sz, left_sz, end_addr;
   assign req_sz   = VW'(req_ff.req_size);
   assign left_sz  = bent_ff.size - req_sz;
   assign end_addr = acc_ff.start + HDR + acc_ff.size;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      count_in = count_ff;
      top_in   = top_ff;
      ptr_in   = ptr_ff;
      wptr_in  = wptr_ff;
      rv_in    = 1'b0;
      rix_in   = ptr_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bent_in  = bent_ff;
      acc_in   = acc_ff;
      accv_in  = accv_ff;
      ins_in   = ins_ff;
      insk_in  = insk_ff;
      wr_en    = 1'b0;
      wr_addr  = IW'(wptr_ff);
      wr_data  = acc_ff;
      rd_addr  = IW'(ptr_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               ptr_in   = '0;
               wptr_in  = '0;
               found_in = 1'b0;
               accv_in  = 1'b0;
               rsp_in   = '{payload_addr: '0, status: ST_OK};
               case (cmd_type'(req_payload.cmd))
                  CMD_ALLOC: begin
                     if (req_payload.req_size == '0) begin
                        rsp_in.status = ST_BAD_SIZE;
                        state_in = S_RSP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FREE: state_in = S_SCAN;
                  CMD_CLEAR: begin
                     count_in = '0;
                     top_in   = '0;
                     state_in = S_RSP;
                  end
                  default: begin
                     rsp_in.status = ST_BAD_SIZE;
                     state_in = S_RSP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue read of ptr, check data of previous read
            if (ptr_ff < count_ff) begin
               rv_in  = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rv_ff) begin
               if (req_ff.cmd == CMD_ALLOC) begin
                  if (rd_data.free && rd_data.size >= req_sz &&
                      (!found_ff || rd_data.size < bent_ff.size)) begin
                     found_in = 1'b1;
                     best_in  = IW'(rix_ff);
                     bent_in  = rd_data;
                  end
               end else if (rd_data.start + HDR == VW'(req_ff.block_addr)) begin
                  // mark free, then compact the whole table from index 0
                  found_in = 1'b1;
                  best_in  = IW'(rix_ff);
                  wr_en    = 1'b1;
                  wr_addr  = IW'(rix_ff);
                  wr_data  = '{start: rd_data.start, size: rd_data.size, free: 1'b1};
                  ptr_in   = '0;
                  wptr_in  = '0;
                  rv_in    = 1'b0;
                  state_in = S_COMP;
               end
            end
            if (state_in == S_SCAN && !rv_in && !(ptr_ff < count_ff)) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (req_ff.cmd == CMD_FREE) begin
               rsp_in.status = ST_NOT_FOUND;
               state_in = S_RSP;
            end else if (found_ff) begin
               rsp_in.payload_addr = 16'(bent_ff.start + HDR);
               if (left_sz >= HDR && count_ff < CW'(MAX_SEGMENTS)) begin
                  ins_in  = '{start: bent_ff.start + HDR + req_sz,
                              size: left_sz - HDR, free: 1'b1};
                  insk_in = CW'(best_ff) + 1'b1;
                  ptr_in  = count_ff;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_FIX;
               end
            end else if (count_ff >= CW'(MAX_SEGMENTS) ||
                         top_ff + HDR + req_sz > eff_limit) begin
               rsp_in.status = ST_NO_SPACE;
               state_in = S_RSP;
            end else begin
               rsp_in.payload_addr = 16'(top_ff + HDR);
               ins_in  = '{start: top_ff, size: req_sz, free: 1'b0};
               insk_in = count_ff;
               top_in  = top_ff + HDR + req_sz;
               ptr_in  = count_ff;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // ptr is the destination; read ptr-1, write on arrival
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(rix_ff + 1'b1);
               wr_data = rd_data;
            end
            if (ptr_ff > insk_ff) begin
               rd_addr = IW'(ptr_ff - 1'b1);
               rv_in   = 1'b1;
               rix_in  = ptr_ff - 1'b1;
               ptr_in  = ptr_ff - 1'b1;
            end else if (!rv_ff) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(insk_ff);
            wr_data  = ins_ff;
            count_in = count_ff + 1'b1;
            state_in = (found_ff) ? S_FIX : S_RSP;
         end
         S_FIX: begin
            // shrink to the request on a split, else give out the whole segment
            wr_en   = 1'b1;
            wr_addr = best_ff;
            wr_data = '{start: bent_ff.start,
                        size: split_ff ? req_sz : bent_ff.size,
                        free: 1'b0};
            state_in = S_RSP;
         end
         S_COMP: begin
            // stream every entry through a merge accumulator
            if (ptr_ff < count_ff) begin
               rv_in  = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rv_ff) begin
               if (accv_ff && acc_ff.free && rd_data.free && end_addr == rd_data.start) begin
                  acc_in.size = acc_ff.size + HDR + rd_data.size;
               end else begin
                  if (accv_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = IW'(wptr_ff);
                     wr_data = acc_ff;
                     wptr_in = wptr_ff + 1'b1;
                  end
                  acc_in  = (IW'(rix_ff) == best_ff) ?
                            '{start: rd_data.start, size: rd_data.size, free: 1'b1} : rd_data;
                  accv_in = 1'b1;
               end
            end else if (!(ptr_ff < count_ff)) begin
               state_in = S_CFLUSH;
            end
         end
         S_CFLUSH: begin
            wr_en    = accv_ff;
            wr_addr  = IW'(wptr_ff);
            wr_data  = acc_ff;
            count_in = wptr_ff + CW'(accv_ff);
            state_in = S_RSP;
         end
         S_RSP: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign split_in = (state_ff == S_PICK) ? (state_in == S_SHIFT && found_ff) : split_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         rv_ff    <= 1'b0;
         split_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         rv_ff    <= rv_in;
         split_ff <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      ptr_ff   <= ptr_in;
      wptr_ff  <= wptr_in;
      rix_ff   <= rix_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bent_ff  <= bent_in;
      acc_ff   <= acc_in;
      accv_ff  <= accv_in;
      ins_ff   <= ins_in;
      insk_ff  <= insk_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_DONE);
   assign rsp_payload = rsp_ff;

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside a command");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
endmodule
